// ----- src/b2da_pkg.sv -----
// ----------------------------------------------------------------------------
// b2da_pkg
// Shared types and constants for the signed binary to decimal ASCII converter.
// ----------------------------------------------------------------------------
`default_nettype none

package b2da_pkg;

  localparam int unsigned VALUE_W       = 32;
  localparam int unsigned CHAR_W        = 8;
  localparam int unsigned DIGIT_W       = 4;
  localparam int unsigned MAX_DIGITS    = 10;
  localparam int unsigned BITS_PER_STEP = 3;
  localparam int unsigned MAG_W         = 33;
  localparam int unsigned CONV_CYCLES   = MAG_W / BITS_PER_STEP;
  localparam int unsigned CNT_W         = $clog2(CONV_CYCLES);

  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CHAR_NINE  = 8'h39;
  localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;
  localparam logic [CHAR_W-1:0] CHAR_PLUS  = 8'h2B;

  typedef logic [DIGIT_W-1:0] digit_t;
  typedef logic [BITS_PER_STEP-1:0] bits_t;

  typedef struct packed {
    logic                        busy;
    logic                        done;
    logic                        neg;
    logic [MAX_DIGITS-1:0][DIGIT_W-1:0] digits;
  } conv_res_t;

endpackage

`default_nettype wire

// ----- src/b2da_cell.sv -----
// ----------------------------------------------------------------------------
// b2da_cell
// One decimal digit of the shift-and-add-3 chain, three bit steps per cycle while loading or running.
// ----------------------------------------------------------------------------
`default_nettype none

module b2da_cell (
  input  wire                   clk,
  input  wire                   load,
  input  wire                   run,
  input  wire  b2da_pkg::bits_t carry_in,
  output b2da_pkg::bits_t       carry_out,
  output b2da_pkg::digit_t      digit
);
  import b2da_pkg::*;

  digit_t digit_r;
  digit_t digit_nxt;
  bits_t  cout;

  always_comb begin
    digit_t d;
    digit_t adj;
    d    = load ? '0 : digit_r;
    cout = '0;
    for (int s = 0; s < BITS_PER_STEP; s++) begin
      adj = (d >= 4'd5) ? d + 4'd3 : d;
      cout[BITS_PER_STEP-1-s] = adj[DIGIT_W-1];
      d = {adj[DIGIT_W-2:0], carry_in[BITS_PER_STEP-1-s]};
    end
    digit_nxt = d;
  end

  always_ff @(posedge clk) begin
    if (load || run) begin
      digit_r <= digit_nxt;
    end
  end

  assign carry_out = cout;
  assign digit     = digit_r;

endmodule

`default_nettype wire

// ----- src/b2da_conv.sv -----
// ----------------------------------------------------------------------------
// b2da_conv
// Magnitude shifter, digit cell row and sequencing for one value at a time.
// ----------------------------------------------------------------------------
`default_nettype none

module b2da_conv (
  input  wire                              clk,
  input  wire                              rst_n,
  input  wire                              in_valid,
  output logic                             in_stall,
  input  wire  [b2da_pkg::VALUE_W-1:0]     in_value,
  input  wire                              load_ok,
  output b2da_pkg::conv_res_t              res
);
  import b2da_pkg::*;

  logic             busy_r, busy_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [MAG_W-1:0] mag_r;
  logic             neg_r;
  logic             done;
  logic             accept;
  logic             run;
  logic [MAG_W-1:0] mag_in;
  bits_t            carry [MAX_DIGITS+1];
  digit_t           digits [MAX_DIGITS];

  assign done     = busy_r && (cnt_r == '0);
  assign run      = busy_r && (cnt_r != '0);
  assign in_stall = busy_r && !(done && load_ok);
  assign accept   = in_valid && !in_stall;
  assign mag_in   = {1'b0, in_value[VALUE_W-1] ? (VALUE_W'(0) - in_value) : in_value};

  always_comb begin
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    if (accept) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CNT_W'(CONV_CYCLES - 1);
    end else if (done && load_ok) begin
      busy_nxt = 1'b0;
    end else if (run) begin
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      mag_r <= mag_in << BITS_PER_STEP;
      neg_r <= in_value[VALUE_W-1];
    end else if (run) begin
      mag_r <= mag_r << BITS_PER_STEP;
    end
  end

  assign carry[0] = accept ? mag_in[MAG_W-1 -: BITS_PER_STEP] : mag_r[MAG_W-1 -: BITS_PER_STEP];

  for (genvar i = 0; i < MAX_DIGITS; i++) begin : g_cell
    b2da_cell u_cell (
      .clk       (clk),
      .load      (accept),
      .run       (run),
      .carry_in  (carry[i]),
      .carry_out (carry[i+1]),
      .digit     (digits[i])
    );
  end

  always_comb begin
    res.busy = busy_r;
    res.done = done;
    res.neg  = neg_r;
    for (int i = 0; i < MAX_DIGITS; i++) begin
      res.digits[i] = digits[i];
    end
  end

endmodule

`default_nettype wire

// ----- src/b2da_emit.sv -----
// ----------------------------------------------------------------------------
// b2da_emit
// Character shift row: takes a finished conversion and sends it out MSB first.
// ----------------------------------------------------------------------------
`default_nettype none

module b2da_emit #(
  parameter int unsigned DIGITS = 10
) (
  input  wire                           clk,
  input  wire                           rst_n,
  input  wire  b2da_pkg::conv_res_t     res,
  output logic                          load_ok,
  output logic                          out_valid,
  input  wire                           out_stall,
  output logic [b2da_pkg::CHAR_W-1:0]   out_character,
  output logic                          out_last_char
);
  import b2da_pkg::*;

  localparam int unsigned LW = $clog2(DIGITS + 2);

  logic [LW-1:0]     left_r, left_nxt;
  logic [CHAR_W-1:0] chr_r [DIGITS+1];
  logic              load;
  logic              beat;

  assign out_valid     = (left_r != '0);
  assign out_last_char = (left_r == LW'(1));
  assign out_character = chr_r[0];
  assign beat          = out_valid && !out_stall;
  assign load_ok       = (left_r == '0) || (out_last_char && !out_stall);
  assign load          = res.done && load_ok;

  always_comb begin
    left_nxt = left_r;
    if (load) begin
      left_nxt = LW'(DIGITS + 1);
    end else if (beat) begin
      left_nxt = left_r - LW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      left_r <= '0;
    end else begin
      left_r <= left_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      chr_r[0] <= res.neg ? CHAR_MINUS : CHAR_PLUS;
      for (int k = 1; k <= DIGITS; k++) begin
        chr_r[k] <= CHAR_ZERO + {4'b0, res.digits[DIGITS-k]};
      end
    end else if (beat) begin
      for (int k = 0; k < DIGITS; k++) begin
        chr_r[k] <= chr_r[k+1];
      end
    end
  end

endmodule

`default_nettype wire

// ----- src/signed_binary_to_decimal_ascii.sv -----
// ----------------------------------------------------------------------------
// signed_binary_to_decimal_ascii
// Converts a signed 32-bit value to a sign character and zero-padded digits.
// ----------------------------------------------------------------------------
//  channel | ports                               | beat
//  --------+-------------------------------------+------------------------
//  in      | in_valid, in_stall, in_value        | one value
//  out     | out_valid, out_stall, out_character,| one ASCII character,
//          | out_last_char                       | last_char on final digit
//
//  The digit cell row takes in three magnitude bits per cycle while it runs,
//  then the shift row sends NDIG+1 character beats (NDIG is DIGIT_COUNT
//  clamped to 1..10). Conversion of the next value overlaps output of the
//  current one. Reset clears both stages. out_stall holds the shift row; a
//  finished conversion waits in the cells.
// ----------------------------------------------------------------------------
`default_nettype none

module signed_binary_to_decimal_ascii #(
  parameter int DIGIT_COUNT = 10
) (
  input  wire                             clk,
  input  wire                             rst_n,
  input  wire                             in_valid,
  output logic                            in_stall,
  input  wire  signed [b2da_pkg::VALUE_W-1:0] in_value,
  output logic                            out_valid,
  input  wire                             out_stall,
  output logic [b2da_pkg::CHAR_W-1:0]     out_character,
  output logic                            out_last_char
);
  import b2da_pkg::*;

  localparam int unsigned NDIG = (DIGIT_COUNT < 1) ? 1 :
                                 (DIGIT_COUNT > int'(MAX_DIGITS)) ? MAX_DIGITS : DIGIT_COUNT;

  conv_res_t res;
  logic      load_ok;

  b2da_conv u_conv (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_value (in_value),
    .load_ok  (load_ok),
    .res      (res)
  );

  b2da_emit #(
    .DIGITS (NDIG)
  ) u_emit (
    .clk           (clk),
    .rst_n         (rst_n),
    .res           (res),
    .load_ok       (load_ok),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_character (out_character),
    .out_last_char (out_last_char)
  );

  a_accept_only_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && res.busy) |-> (res.done && load_ok))
    else $error("value accepted while conversion still in progress");

  a_run_continues: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_last_char && !out_stall) |=> out_valid)
    else $error("character run ended before last character");

  a_gap_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_last_char && !out_stall && !res.done) |=> !out_valid)
    else $error("characters appeared without a finished conversion");

  a_char_legal: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_character >= CHAR_ZERO && out_character <= CHAR_NINE) ||
                   out_character == CHAR_PLUS || out_character == CHAR_MINUS))
    else $error("illegal output character");

endmodule

`default_nettype wire
